// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of the circular FIFO block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CFS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/cfs_pkg.sv -----
// Shared types and constants of the circular FIFO with search.
// Depends on nothing; used by the front, back, top and checker files.
package cfs_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int WORD_W        = 32;
  localparam int CMD_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int SLOT_W        = 7;
  localparam int COUNT_W       = 8;
  localparam int CMDQ_DEPTH    = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         op;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     found;
    logic [SLOT_W-1:0]        slot_index;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic                     is_full;
    logic signed [WORD_W-1:0] head_value;
    logic signed [WORD_W-1:0] tail_value;
  } res_t;

endpackage

// ----- sv/cfs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module cfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/cfs_front.sv -----
// Front end of the circular FIFO: takes commands, decodes them and holds them
// in a short command queue for the back end. Depends on cfs_pkg.
module cfs_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [cfs_pkg::CMD_W-1:0]    command,
  input  logic signed [cfs_pkg::WORD_W-1:0] value,
  output logic                         cmd_valid,
  output cfs_pkg::cmd_t                cmd,
  input  logic                         cmd_take
);
  import cfs_pkg::*;

  localparam int QW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          q [CMDQ_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [CW-1:0] cnt;
  cmd_t          decoded;
  logic          wr_en;

  function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
    return (p == QW'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    decoded.value = value;
    case (command)
      CMD_PUSH:   decoded.op = CMD_PUSH;
      CMD_POP:    decoded.op = CMD_POP;
      CMD_SEARCH: decoded.op = CMD_SEARCH;
      default:    decoded.op = CMD_NOP;
    endcase
  end

  assign full      = (cnt == CW'(CMDQ_DEPTH));
  assign wr_en     = push && !full;
  assign cmd_valid = (cnt != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (cmd_take) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({wr_en, cmd_take})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// ----- sv/cfs_back.sv -----
// Back end of the circular FIFO: executes push, pop and search against the
// slot memory and holds the result register. Depends on cfs_pkg and cfs_ram.
module cfs_back #(
  parameter int DEPTH = cfs_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  cfs_pkg::cmd_t cmd,
  output logic          cmd_take,
  output logic          res_valid,
  output cfs_pkg::res_t res,
  input  logic          res_pop
);
  import cfs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HEAD = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]               state, state_next;
  logic [AW-1:0]            head_slot, head_slot_next;
  logic [AW-1:0]            tail_slot, tail_slot_next;
  logic [CW-1:0]            occ, occ_next;
  logic signed [WORD_W-1:0] head_val, head_val_next;
  logic signed [WORD_W-1:0] tail_val, tail_val_next;
  logic signed [WORD_W-1:0] key, key_next;
  logic [AW-1:0]            iss_slot, iss_slot_next;
  logic [CW-1:0]            iss_cnt, iss_cnt_next;
  logic                     pend, pend_next;
  logic [AW-1:0]            pend_slot, pend_slot_next;

  logic                     advance;
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;
  logic                     res_we;
  logic [STATUS_W-1:0]      r_status;
  logic                     r_found;
  logic [AW-1:0]            r_slot;
  logic [AW+SLOT_W-1:0]     slot_wide;
  logic [CW+COUNT_W-1:0]    count_wide;
  res_t                     res_next;

  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    return (s == AW'(DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  cfs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(cmd.value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign advance  = !res_valid || res_pop;
  assign cmd_take = advance && cmd_valid && (state == S_IDLE);

  always_comb begin
    state_next     = state;
    head_slot_next = head_slot;
    tail_slot_next = tail_slot;
    occ_next       = occ;
    head_val_next  = head_val;
    tail_val_next  = tail_val;
    key_next       = key;
    iss_slot_next  = iss_slot;
    iss_cnt_next   = iss_cnt;
    pend_next      = pend;
    pend_slot_next = pend_slot;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = slot_inc(tail_slot);
    ram_raddr      = iss_slot;
    res_we         = 1'b0;
    r_status       = ST_DONE;
    r_found        = 1'b0;
    r_slot         = '0;
    case (state)
      S_IDLE: begin
        if (cmd_take) begin
          case (cmd.op)
            CMD_PUSH: begin
              res_we = 1'b1;
              if (occ == CW'(DEPTH)) begin
                r_status = ST_FULL;
              end else begin
                tail_slot_next = slot_inc(tail_slot);
                ram_we         = 1'b1;
                tail_val_next  = cmd.value;
                occ_next       = occ + 1'b1;
                if (occ == '0) begin
                  head_val_next = cmd.value;
                end
              end
            end
            CMD_POP: begin
              if (occ == '0) begin
                r_status = ST_EMPTY;
                res_we   = 1'b1;
              end else begin
                head_slot_next = slot_inc(head_slot);
                occ_next       = occ - 1'b1;
                if (occ == CW'(1)) begin
                  res_we = 1'b1;
                end else begin
                  ram_re     = 1'b1;
                  ram_raddr  = slot_inc(head_slot);
                  state_next = S_HEAD;
                end
              end
            end
            CMD_SEARCH: begin
              if (occ == '0) begin
                r_status = ST_EMPTY;
                res_we   = 1'b1;
              end else begin
                key_next      = cmd.value;
                iss_slot_next = head_slot;
                iss_cnt_next  = '0;
                pend_next     = 1'b0;
                state_next    = S_SCAN;
              end
            end
            default: begin
              res_we = 1'b1;
            end
          endcase
        end
      end
      S_HEAD: begin
        if (advance) begin
          head_val_next = ram_rdata;
          res_we        = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (advance) begin
          if (pend && (ram_rdata == key)) begin
            r_found    = 1'b1;
            r_slot     = pend_slot;
            res_we     = 1'b1;
            state_next = S_IDLE;
          end else if (pend && (iss_cnt == occ)) begin
            res_we     = 1'b1;
            state_next = S_IDLE;
          end else begin
            ram_re         = 1'b1;
            ram_raddr      = iss_slot;
            pend_next      = 1'b1;
            pend_slot_next = iss_slot;
            iss_slot_next  = slot_inc(iss_slot);
            iss_cnt_next   = iss_cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign slot_wide  = {{SLOT_W{1'b0}}, r_slot};
  assign count_wide = {{COUNT_W{1'b0}}, occ_next};

  always_comb begin
    res_next.status      = r_status;
    res_next.found       = r_found;
    res_next.slot_index  = slot_wide[SLOT_W-1:0];
    res_next.entry_count = count_wide[COUNT_W-1:0];
    res_next.is_empty    = (occ_next == '0);
    res_next.is_full     = (occ_next == CW'(DEPTH));
    res_next.head_value  = (occ_next == '0) ? '0 : head_val_next;
    res_next.tail_value  = (occ_next == '0) ? '0 : tail_val_next;
  end

  always_ff @(posedge clk) begin
    head_val  <= head_val_next;
    tail_val  <= tail_val_next;
    key       <= key_next;
    iss_slot  <= iss_slot_next;
    iss_cnt   <= iss_cnt_next;
    pend_slot <= pend_slot_next;
    if (res_we) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_slot <= '0;
      tail_slot <= AW'(DEPTH - 1);
      occ       <= '0;
      pend      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head_slot <= head_slot_next;
      tail_slot <= tail_slot_next;
      occ       <= occ_next;
      pend      <= pend_next;
      if (res_we) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/circular_fifo_with_search_top.sv -----
// Circular FIFO of signed 32-bit words with push, pop and search commands;
// every command yields exactly one result. Commands enter a two-entry command
// queue and are executed one at a time by the back end. Push, a rejected
// command and the undefined command finish in the idle state; a pop that
// leaves entries also passes through the head state, since the new head word
// is read from the slot memory. A search reads one slot per cycle through the
// single read port of the slot memory, starting at the head, and ends at the
// first match or, without a match, once every entry has been read.
// A result waits in an output register, and the back end takes the next
// command only once that result is read, at the earliest in the same cycle;
// meanwhile the command queue keeps accepting up to two transactions.
// Depends on cfs_pkg, cfs_front and cfs_back.
module circular_fifo_with_search_top #(
  parameter int DEPTH = cfs_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [cfs_pkg::CMD_W-1:0]           command,
  input  logic signed [cfs_pkg::WORD_W-1:0]   value,
  output logic                                empty,
  input  logic                                pop,
  output logic [cfs_pkg::STATUS_W-1:0]        status,
  output logic                                found,
  output logic [cfs_pkg::SLOT_W-1:0]          slot_index,
  output logic [cfs_pkg::COUNT_W-1:0]         entry_count,
  output logic                                is_empty,
  output logic                                is_full,
  output logic signed [cfs_pkg::WORD_W-1:0]   head_value,
  output logic signed [cfs_pkg::WORD_W-1:0]   tail_value
);
  import cfs_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic res_valid;
  res_t res;

  cfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .command  (command),
    .value    (value),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  cfs_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .res_valid(res_valid),
    .res      (res),
    .res_pop  (pop && res_valid)
  );

  assign empty       = !res_valid;
  assign status      = res.status;
  assign found       = res.found;
  assign slot_index  = res.slot_index;
  assign entry_count = res.entry_count;
  assign is_empty    = res.is_empty;
  assign is_full     = res.is_full;
  assign head_value  = res.head_value;
  assign tail_value  = res.tail_value;

endmodule

// ----- sv/cfs_checker.sv -----
// Port-level checker of the circular FIFO with search, bound to the top level.
// Depends on cfs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              empty,
  input logic                              pop,
  input logic [cfs_pkg::STATUS_W-1:0]      status,
  input logic                              found,
  input logic                              is_empty,
  input logic                              is_full,
  input logic signed [cfs_pkg::WORD_W-1:0] head_value,
  input logic signed [cfs_pkg::WORD_W-1:0] tail_value
);
  import cfs_pkg::*;

  `CFS_ASSERT_IMP(a_empty_values_zero, clk, rst, !empty && is_empty, head_value == 0 && tail_value == 0)
  `CFS_ASSERT_IMP(a_found_means_done, clk, rst, !empty && found, status == ST_DONE)
  `CFS_ASSERT_IMP(a_full_reject_flag, clk, rst, !empty && status == ST_FULL, is_full && !is_empty)
  `CFS_ASSERT_IMP(a_empty_reject_flag, clk, rst, !empty && status == ST_EMPTY, is_empty && !found)
  `CFS_ASSERT_NXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(status) && $stable(tail_value))

endmodule

bind circular_fifo_with_search_top cfs_checker u_cfs_checker (.*);
